// ===== rtl/ncs_pkg.sv =====
// ----------------------------------------------------------------------------
// Natural cubic spline coefficients: shared package
// Sizes, status codes, arithmetic unit request types and saturation helpers.
// ----------------------------------------------------------------------------
package ncs_pkg;

   // Store depth and fixed-point format.
   localparam int MAX_POINTS = 32;
   localparam int FRAC_BITS  = 16;

   // Derived widths.
   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int PCNT_W = $clog2(MAX_POINTS + 1);
   localparam int DIV_W  = 64 + FRAC_BITS;
   localparam int ACNT_W = $clog2(DIV_W + 1);

   // Saturation limit of the intermediates and the constant six in fixed point.
   localparam logic signed [63:0] LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SIX_Q = 64'sd6 <<< FRAC_BITS;

   // Reciprocal of six scaled by 2^64, rounded up. The top 64 bits of the
   // product with a magnitude below 2^62 give the exact truncated quotient.
   localparam logic [63:0] RECIP6 = 64'h2AAA_AAAA_AAAA_AAAB;

   // Result status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FEW     = 2'd1;
   localparam logic [1:0] STATUS_NOT_INC = 2'd2;
   localparam logic [1:0] STATUS_DROPPED = 2'd3;

   // Operations of the shared arithmetic unit.
   typedef enum logic [1:0] {
      OP_MUL    = 2'd0,   // (a*b) >> FRAC_BITS
      OP_DIV    = 2'd1,   // (a << FRAC_BITS) / b
      OP_DIV6   = 2'd2    // a / 6, b unused
   } arith_op_type;

   typedef struct packed {
      logic               start;
      arith_op_type       op;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } arith_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] result;
   } arith_rsp_type;

   // Clamp a widened sum to +-LIM.
   function automatic logic signed [63:0] sat_lim(input logic signed [64:0] v);
      logic signed [63:0] r;
      if (v > 65'(LIM)) begin
         r = LIM;
      end else if (v < -65'(LIM)) begin
         r = -LIM;
      end else begin
         r = 64'(v);
      end
      return r;
   endfunction

   // Clamp to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   // Magnitude of a value after clamping to +-LIM.
   function automatic logic [63:0] mag(input logic signed [63:0] v);
      logic signed [63:0] s;
      s = sat_lim(65'(v));
      return (s < 0) ? 64'(-s) : 64'(s);
   endfunction

endpackage

// ===== rtl/ncs_arith.sv =====
// ----------------------------------------------------------------------------
// Natural cubic spline coefficients: shared arithmetic unit
// Bit-serial fixed-point multiplier and restoring divider, one bit a cycle.
// Division by six runs on the multiplier as a reciprocal multiplication.
// ----------------------------------------------------------------------------
module ncs_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  ncs_pkg::arith_req_type req,
   output ncs_pkg::arith_rsp_type rsp
);

   logic                       busy_ff, busy_in;
   logic                       fin_ff, fin_in;
   logic                       done_ff, done_in;
   logic                       mul_ff, mul_in;
   logic                       div6_ff, div6_in;
   logic                       neg_ff, neg_in;
   logic                       zero_ff, zero_in;
   logic [ncs_pkg::ACNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]                opa_ff, opa_in;
   logic [63:0]                opb_ff, opb_in;
   logic [63:0]                acc_ff, acc_in;
   logic [63:0]                lo_ff, lo_in;
   logic [63:0]                rem_ff, rem_in;
   logic [ncs_pkg::DIV_W-1:0]  dvd_ff, dvd_in;
   logic [ncs_pkg::DIV_W-1:0]  quot_ff, quot_in;
   logic signed [63:0]         res_ff, res_in;

   logic [64:0]  mul_sum;
   logic [64:0]  rem_sh;
   logic [64:0]  rem_diff;
   logic [127:0] prod;
   logic [63:0]  mag_res;
   logic [63:0]  ua;
   logic [63:0]  ub;

   assign ua      = ncs_pkg::mag(req.a);
   assign ub      = ncs_pkg::mag(req.b);
   assign mul_sum = {1'b0, acc_ff} + {1'b0, (opb_ff[0] ? opa_ff : 64'd0)};
   assign rem_sh  = {rem_ff, dvd_ff[ncs_pkg::DIV_W-1]};
   assign rem_diff = rem_sh - {1'b0, opb_ff};
   assign prod    = {acc_ff, lo_ff};

   // Final magnitude with saturation above LIM.
   always_comb begin
      if (mul_ff && div6_ff) begin
         mag_res = prod[127:64];
      end else if (mul_ff) begin
         if (|prod[127:62+ncs_pkg::FRAC_BITS]) begin
            mag_res = 64'(ncs_pkg::LIM);
         end else begin
            mag_res = 64'(prod[61+ncs_pkg::FRAC_BITS:ncs_pkg::FRAC_BITS]);
         end
      end else if (zero_ff) begin
         mag_res = 64'd0;
      end else if (|quot_ff[ncs_pkg::DIV_W-1:62]) begin
         mag_res = 64'(ncs_pkg::LIM);
      end else begin
         mag_res = 64'(quot_ff[61:0]);
      end
   end

   // Sequencing of one operation.
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      mul_in  = mul_ff;
      div6_in = div6_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      res_in  = res_ff;
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         neg_in  = (req.a < 0) != (req.b < 0);
         zero_in = (ub == 64'd0);
         opb_in  = ub;
         div6_in = (req.op == ncs_pkg::OP_DIV6);
         if (req.op == ncs_pkg::OP_MUL || req.op == ncs_pkg::OP_DIV6) begin
            mul_in = 1'b1;
            opa_in = ua;
            acc_in = 64'd0;
            lo_in  = 64'd0;
            cnt_in = ncs_pkg::ACNT_W'(64);
            if (req.op == ncs_pkg::OP_DIV6) begin
               opb_in = ncs_pkg::RECIP6;
            end
         end else begin
            mul_in  = 1'b0;
            rem_in  = 64'd0;
            quot_in = '0;
            cnt_in  = ncs_pkg::ACNT_W'(ncs_pkg::DIV_W);
            dvd_in  = ncs_pkg::DIV_W'(ua) << ncs_pkg::FRAC_BITS;
         end
      end else if (busy_ff) begin
         if (mul_ff) begin
            acc_in = mul_sum[64:1];
            lo_in  = {mul_sum[0], lo_ff[63:1]};
            opb_in = opb_ff >> 1;
         end else begin
            dvd_in = dvd_ff << 1;
            if (!rem_diff[64]) begin
               rem_in  = rem_diff[63:0];
               quot_in = {quot_ff[ncs_pkg::DIV_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[63:0];
               quot_in = {quot_ff[ncs_pkg::DIV_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ncs_pkg::ACNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         res_in  = neg_ff ? -$signed(mag_res) : $signed(mag_res);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      mul_ff  <= mul_in;
      div6_ff <= div6_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      acc_ff  <= acc_in;
      lo_ff   <= lo_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
      res_ff  <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

// ===== rtl/natural_cubic_spline_coefficients_core.sv =====
// ----------------------------------------------------------------------------
// Natural cubic spline coefficients core
// Stores points, solves for the second derivatives with a Thomas sweep and
// emits the cubic coefficients of every segment.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_*    in         one point (x, y), tlast marks the last point of a set
//  rsp_*    out        one segment's coefficients, tuser = status, tlast = last
//
// Plain points are taken back to back while the block is idle. After the last
// point the block stays busy while every step runs on one bit-serial unit, a
// multiply (also the division by six) or a divide at a time, with six such
// operations per interior point in the forward sweep, one per interior point
// in the back substitution and five per segment in the output pass. Reset
// clears the point count and flags; the stores need no clearing. A stalled
// result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
module natural_cubic_spline_coefficients_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // x_value[31:0], y_value[63:32]
   input  logic         req_tlast,   // last_point
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,   // segment_index[4:0], segment_start[36:5],
                                     // coef_cubic[68:37], coef_square[100:69],
                                     // coef_linear[132:101], coef_constant[164:133]
   output logic [1:0]   rsp_tuser,   // status[1:0]
   output logic         rsp_tlast    // last_segment
);

   localparam int IW = ncs_pkg::IDX_W;
   localparam int CW = ncs_pkg::PCNT_W;

   typedef enum logic [25:0] {
      ST_IDLE = 26'd1 << 0,
      ST_FL0  = 26'd1 << 1,
      ST_FL1  = 26'd1 << 2,
      ST_FL2  = 26'd1 << 3,
      ST_FP   = 26'd1 << 4,
      ST_FK   = 26'd1 << 5,
      ST_FK2  = 26'd1 << 6,
      ST_FD1  = 26'd1 << 7,
      ST_FM1  = 26'd1 << 8,
      ST_FM2  = 26'd1 << 9,
      ST_FD2  = 26'd1 << 10,
      ST_FM3  = 26'd1 << 11,
      ST_FD3  = 26'd1 << 12,
      ST_BI   = 26'd1 << 13,
      ST_BA   = 26'd1 << 14,
      ST_BM   = 26'd1 << 15,
      ST_BZ   = 26'd1 << 16,
      ST_OA   = 26'd1 << 17,
      ST_OB   = 26'd1 << 18,
      ST_OC   = 26'd1 << 19,
      ST_OD1  = 26'd1 << 20,
      ST_OM1  = 26'd1 << 21,
      ST_OD2  = 26'd1 << 22,
      ST_OM2  = 26'd1 << 23,
      ST_OD3  = 26'd1 << 24,
      ST_OUT  = 26'd1 << 25
   } state_type;

   state_type state_ff, state_in;

   // Control registers.
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic          bad_ff, bad_in;
   logic          issued_ff, issued_in;
   logic [IW-1:0] k_ff, k_in;

   // Working registers.
   logic signed [31:0] prevx_ff, prevx_in;
   logic signed [31:0] xa_ff, xa_in, xb_ff, xb_in, xc_ff, xc_in;
   logic signed [31:0] ya_ff, ya_in, yb_ff, yb_in, yc_ff, yc_in;
   logic signed [31:0] s0_ff, s0_in, s1_ff, s1_in;
   logic signed [31:0] sfp_ff, sfp_in, srp_ff, srp_in, snext_ff, snext_in;
   logic signed [63:0] fp_ff, fp_in, fn_ff, fn_in;
   logic signed [63:0] r_ff, r_in, m_ff, m_in, t_ff, t_in;

   // Result registers.
   logic [4:0]         o_idx_ff, o_idx_in;
   logic signed [31:0] o_start_ff, o_start_in;
   logic signed [31:0] o_cubic_ff, o_cubic_in;
   logic signed [31:0] o_square_ff, o_square_in;
   logic signed [31:0] o_linear_ff, o_linear_in;
   logic signed [31:0] o_const_ff, o_const_in;
   logic [1:0]         o_status_ff, o_status_in;
   logic               o_last_ff, o_last_in;

   // Stores.
   logic signed [31:0] x_mem  [ncs_pkg::MAX_POINTS];
   logic signed [31:0] y_mem  [ncs_pkg::MAX_POINTS];
   logic signed [31:0] s_mem  [ncs_pkg::MAX_POINTS];
   logic signed [31:0] sf_mem [ncs_pkg::MAX_POINTS];
   logic signed [31:0] sr_mem [ncs_pkg::MAX_POINTS];
   logic signed [31:0] rd_x_ff, rd_y_ff, rd_s_ff, rd_sf_ff, rd_sr_ff;
   logic [IW-1:0]      rd_addr;
   logic               xy_we;
   logic               s_we;
   logic [IW-1:0]      s_waddr;
   logic signed [31:0] s_wdata;
   logic               sf_we;
   logic               sr_we;
   logic signed [31:0] sf_new;
   logic signed [31:0] sr_new;
   logic signed [31:0] sk_new;

   // Arithmetic unit.
   ncs_pkg::arith_req_type areq;
   ncs_pkg::arith_rsp_type arsp;
   logic                   op_state;

   // Input item and derived values.
   logic               accept;
   logic               room;
   logic signed [31:0] in_x;
   logic signed [31:0] in_y;
   logic [CW-1:0]      cnt_new;
   logic               bad_new;
   logic               ovf_new;
   logic signed [63:0] hp;
   logic signed [63:0] hn;
   logic signed [63:0] ho;
   logic signed [32:0] half_s0;
   logic [1:0]         seg_status;

   assign in_x       = $signed(req_tdata[31:0]);
   assign in_y       = $signed(req_tdata[63:32]);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign room       = (cnt_ff < CW'(ncs_pkg::MAX_POINTS));
   assign cnt_new    = room ? cnt_ff + 1'b1 : cnt_ff;
   assign bad_new    = bad_ff | (room && (cnt_ff != '0) && (in_x <= prevx_ff));
   assign ovf_new    = ovf_ff | !room;
   assign xy_we      = accept && room;
   assign hp         = 64'(xb_ff) - 64'(xa_ff);
   assign hn         = 64'(xc_ff) - 64'(xb_ff);
   assign ho         = 64'(xb_ff) - 64'(xa_ff);
   assign half_s0    = (33'(s0_ff) + ((s0_ff < 0) ? 33'sd1 : 33'sd0)) >>> 1;
   assign seg_status = ovf_ff ? ncs_pkg::STATUS_DROPPED : ncs_pkg::STATUS_OK;
   assign sf_new     = ncs_pkg::sat32(arsp.result);
   assign sr_new     = ncs_pkg::sat32(arsp.result);
   assign sk_new     = ncs_pkg::sat32(ncs_pkg::sat_lim(65'(rd_sr_ff) - 65'(arsp.result)));

   // Store ports: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (xy_we) begin
         x_mem[cnt_ff[IW-1:0]] <= in_x;
         y_mem[cnt_ff[IW-1:0]] <= in_y;
      end
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         s_mem[s_waddr] <= s_wdata;
      end
      rd_s_ff <= s_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (sf_we) begin
         sf_mem[k_ff] <= sf_new;
      end
      rd_sf_ff <= sf_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (sr_we) begin
         sr_mem[k_ff] <= sr_new;
      end
      rd_sr_ff <= sr_mem[rd_addr];
   end

   ncs_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (areq),
      .rsp   (arsp)
   );

   // Operation issued to the arithmetic unit in each working state.
   always_comb begin
      op_state = 1'b1;
      areq.op  = ncs_pkg::OP_DIV;
      areq.a   = 64'sd0;
      areq.b   = 64'sd0;
      unique case (state_ff)
         ST_FP, ST_FD1: begin
            areq.a = 64'(yc_ff) - 64'(yb_ff);
            areq.b = hn;
         end
         ST_FM1: begin
            areq.op = ncs_pkg::OP_MUL;
            areq.a  = ncs_pkg::sat_lim(65'(fn_ff) - 65'(fp_ff));
            areq.b  = ncs_pkg::SIX_Q;
         end
         ST_FM2: begin
            areq.op = ncs_pkg::OP_MUL;
            areq.a  = hp;
            areq.b  = 64'(sfp_ff);
         end
         ST_FD2: begin
            areq.a = hn;
            areq.b = m_ff;
         end
         ST_FM3: begin
            areq.op = ncs_pkg::OP_MUL;
            areq.a  = hp;
            areq.b  = 64'(srp_ff);
         end
         ST_FD3: begin
            areq.a = ncs_pkg::sat_lim(65'(r_ff) - 65'(t_ff));
            areq.b = m_ff;
         end
         ST_BM: begin
            areq.op = ncs_pkg::OP_MUL;
            areq.a  = 64'(rd_sf_ff);
            areq.b  = 64'(snext_ff);
         end
         ST_OD1: begin
            areq.a = 64'(yb_ff) - 64'(ya_ff);
            areq.b = ho;
         end
         ST_OM1: begin
            areq.op = ncs_pkg::OP_MUL;
            areq.a  = ho;
            areq.b  = ncs_pkg::SIX_Q;
         end
         ST_OD2: begin
            areq.a = 64'(s1_ff) - 64'(s0_ff);
            areq.b = t_ff;
         end
         ST_OM2: begin
            areq.op = ncs_pkg::OP_MUL;
            areq.a  = 64'(s1_ff) + (64'(s0_ff) <<< 1);
            areq.b  = ho;
         end
         ST_OD3: begin
            areq.op = ncs_pkg::OP_DIV6;
            areq.a  = t_ff;
         end
         default: begin
            op_state = 1'b0;
         end
      endcase
      areq.start = op_state && !issued_ff;
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      bad_in      = bad_ff;
      issued_in   = issued_ff;
      k_in        = k_ff;
      prevx_in    = prevx_ff;
      xa_in       = xa_ff;
      xb_in       = xb_ff;
      xc_in       = xc_ff;
      ya_in       = ya_ff;
      yb_in       = yb_ff;
      yc_in       = yc_ff;
      s0_in       = s0_ff;
      s1_in       = s1_ff;
      sfp_in      = sfp_ff;
      srp_in      = srp_ff;
      snext_in    = snext_ff;
      fp_in       = fp_ff;
      fn_in       = fn_ff;
      r_in        = r_ff;
      m_in        = m_ff;
      t_in        = t_ff;
      o_idx_in    = o_idx_ff;
      o_start_in  = o_start_ff;
      o_cubic_in  = o_cubic_ff;
      o_square_in = o_square_ff;
      o_linear_in = o_linear_ff;
      o_const_in  = o_const_ff;
      o_status_in = o_status_ff;
      o_last_in   = o_last_ff;
      rd_addr     = k_ff;
      s_we        = 1'b0;
      s_waddr     = k_ff;
      s_wdata     = 32'sd0;
      sf_we       = 1'b0;
      sr_we       = 1'b0;

      // Track an outstanding operation of the arithmetic unit.
      if (areq.start) begin
         issued_in = 1'b1;
      end else if (arsp.done) begin
         issued_in = 1'b0;
      end

      unique case (state_ff)
         // Take points; the last one starts the solve or a status result.
         ST_IDLE: begin
            if (accept) begin
               cnt_in = cnt_new;
               bad_in = bad_new;
               ovf_in = ovf_new;
               if (room) begin
                  prevx_in = in_x;
               end
               if (req_tlast) begin
                  if (cnt_new < CW'(3) || bad_new) begin
                     o_idx_in    = 5'd0;
                     o_start_in  = 32'sd0;
                     o_cubic_in  = 32'sd0;
                     o_square_in = 32'sd0;
                     o_linear_in = 32'sd0;
                     o_const_in  = 32'sd0;
                     o_status_in = (cnt_new < CW'(3)) ? ncs_pkg::STATUS_FEW
                                                      : ncs_pkg::STATUS_NOT_INC;
                     o_last_in   = 1'b1;
                     state_in    = ST_OUT;
                  end else begin
                     state_in = ST_FL0;
                  end
               end
            end
         end
         // Forward sweep: load the first two points.
         ST_FL0: begin
            rd_addr  = '0;
            state_in = ST_FL1;
         end
         ST_FL1: begin
            rd_addr  = IW'(1);
            xb_in    = rd_x_ff;
            yb_in    = rd_y_ff;
            state_in = ST_FL2;
         end
         ST_FL2: begin
            xc_in    = rd_x_ff;
            yc_in    = rd_y_ff;
            k_in     = IW'(1);
            sfp_in   = 32'sd0;
            srp_in   = 32'sd0;
            state_in = ST_FP;
         end
         ST_FP: begin
            if (arsp.done) begin
               fn_in    = arsp.result;
               state_in = ST_FK;
            end
         end
         // Slide the three-point window and fetch point k+1.
         ST_FK: begin
            rd_addr  = k_ff + 1'b1;
            xa_in    = xb_ff;
            xb_in    = xc_ff;
            ya_in    = yb_ff;
            yb_in    = yc_ff;
            fp_in    = fn_ff;
            state_in = ST_FK2;
         end
         ST_FK2: begin
            xc_in    = rd_x_ff;
            yc_in    = rd_y_ff;
            state_in = ST_FD1;
         end
         ST_FD1: begin
            if (arsp.done) begin
               fn_in    = arsp.result;
               state_in = ST_FM1;
            end
         end
         ST_FM1: begin
            if (arsp.done) begin
               r_in     = arsp.result;
               state_in = ST_FM2;
            end
         end
         // Pivot of the sweep.
         ST_FM2: begin
            if (arsp.done) begin
               m_in     = ncs_pkg::sat_lim(65'((hp + hn) <<< 1) - 65'(arsp.result));
               state_in = ST_FD2;
            end
         end
         ST_FD2: begin
            if (arsp.done) begin
               sf_we    = 1'b1;
               sfp_in   = sf_new;
               state_in = ST_FM3;
            end
         end
         ST_FM3: begin
            if (arsp.done) begin
               t_in     = arsp.result;
               state_in = ST_FD3;
            end
         end
         ST_FD3: begin
            if (arsp.done) begin
               sr_we  = 1'b1;
               srp_in = sr_new;
               if (CW'(k_ff) + CW'(2) < cnt_ff) begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_FK;
               end else begin
                  state_in = ST_BI;
               end
            end
         end
         // Back substitution from the far end.
         ST_BI: begin
            s_we     = 1'b1;
            s_waddr  = IW'(cnt_ff - 1'b1);
            snext_in = 32'sd0;
            k_in     = IW'(cnt_ff - CW'(2));
            state_in = ST_BA;
         end
         ST_BA: begin
            state_in = ST_BM;
         end
         ST_BM: begin
            if (arsp.done) begin
               s_we     = 1'b1;
               s_wdata  = sk_new;
               snext_in = sk_new;
               if (k_ff == IW'(1)) begin
                  state_in = ST_BZ;
               end else begin
                  k_in     = k_ff - 1'b1;
                  state_in = ST_BA;
               end
            end
         end
         ST_BZ: begin
            s_we     = 1'b1;
            s_waddr  = '0;
            k_in     = '0;
            state_in = ST_OA;
         end
         // Output pass: fetch both ends of segment k.
         ST_OA: begin
            state_in = ST_OB;
         end
         ST_OB: begin
            rd_addr  = k_ff + 1'b1;
            xa_in    = rd_x_ff;
            ya_in    = rd_y_ff;
            s0_in    = rd_s_ff;
            state_in = ST_OC;
         end
         ST_OC: begin
            xb_in    = rd_x_ff;
            yb_in    = rd_y_ff;
            s1_in    = rd_s_ff;
            state_in = ST_OD1;
         end
         ST_OD1: begin
            if (arsp.done) begin
               fp_in    = arsp.result;
               state_in = ST_OM1;
            end
         end
         ST_OM1: begin
            if (arsp.done) begin
               t_in     = arsp.result;
               state_in = ST_OD2;
            end
         end
         ST_OD2: begin
            if (arsp.done) begin
               r_in     = arsp.result;
               state_in = ST_OM2;
            end
         end
         ST_OM2: begin
            if (arsp.done) begin
               t_in     = arsp.result;
               state_in = ST_OD3;
            end
         end
         // Assemble the segment's result.
         ST_OD3: begin
            if (arsp.done) begin
               o_idx_in    = 5'(k_ff);
               o_start_in  = xa_ff;
               o_cubic_in  = ncs_pkg::sat32(r_ff);
               o_square_in = 32'(half_s0);
               o_linear_in = ncs_pkg::sat32(ncs_pkg::sat_lim(65'(fp_ff) - 65'(arsp.result)));
               o_const_in  = ya_ff;
               o_status_in = seg_status;
               o_last_in   = (CW'(k_ff) + CW'(2) == cnt_ff);
               state_in    = ST_OUT;
            end
         end
         // Hold the result until it is taken.
         ST_OUT: begin
            if (rsp_tready) begin
               if (o_last_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  bad_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_OA;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         bad_ff    <= 1'b0;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         bad_ff    <= bad_in;
         issued_ff <= issued_in;
      end
      k_ff        <= k_in;
      prevx_ff    <= prevx_in;
      xa_ff       <= xa_in;
      xb_ff       <= xb_in;
      xc_ff       <= xc_in;
      ya_ff       <= ya_in;
      yb_ff       <= yb_in;
      yc_ff       <= yc_in;
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      sfp_ff      <= sfp_in;
      srp_ff      <= srp_in;
      snext_ff    <= snext_in;
      fp_ff       <= fp_in;
      fn_ff       <= fn_in;
      r_ff        <= r_in;
      m_ff        <= m_in;
      t_ff        <= t_in;
      o_idx_ff    <= o_idx_in;
      o_start_ff  <= o_start_in;
      o_cubic_ff  <= o_cubic_in;
      o_square_ff <= o_square_in;
      o_linear_ff <= o_linear_in;
      o_const_ff  <= o_const_in;
      o_status_ff <= o_status_in;
      o_last_ff   <= o_last_in;
   end

   // Result channel.
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {3'd0, o_const_ff, o_linear_ff, o_square_ff, o_cubic_ff,
                        o_start_ff, o_idx_ff};
   assign rsp_tuser  = o_status_ff;
   assign rsp_tlast  = o_last_ff;

endmodule
